FILE: sv/pba_pkg.sv
`timescale 1ns / 1ps

package pba_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned AmtW  = 10;
  localparam int unsigned OpW   = 4;

  // Register indexes on the configuration port.
  localparam logic CfgIdxOperation = 1'b0;
  localparam logic CfgIdxAmount    = 1'b1;

  typedef enum logic [OpW-1:0] {
    OP_MUL      = 4'd0,
    OP_SUB      = 4'd1,
    OP_OVERLAY  = 4'd2,
    OP_SCREEN   = 4'd3,
    OP_COMBINE  = 4'd4,
    OP_ONLY_R   = 4'd5,
    OP_ONLY_G   = 4'd6,
    OP_ONLY_B   = 4'd7,
    OP_ADD_R    = 4'd8,
    OP_ADD_G    = 4'd9,
    OP_ADD_B    = 4'd10,
    OP_SCALE_R  = 4'd11,
    OP_SCALE_G  = 4'd12,
    OP_SCALE_B  = 4'd13
  } op_e;

  typedef enum logic [2:0] {
    CH_PASS    = 3'd0,
    CH_LAYER   = 3'd1,
    CH_MUL     = 3'd2,
    CH_SUB     = 3'd3,
    CH_OVERLAY = 3'd4,
    CH_SCREEN  = 3'd5,
    CH_ADD     = 3'd6,
    CH_SCALE   = 3'd7
  } chmode_e;

  // Per-pixel control decoded from the operation register.
  typedef struct packed {
    chmode_e    mode_r;
    chmode_e    mode_g;
    chmode_e    mode_b;
    logic [1:0] src_sel;   // base channel fed to all three lanes
    logic       src_one;   // all lanes read the selected base channel
    logic       blue_sec;  // blue lane takes the second layer as its b operand
  } ctrl_t;

  localparam logic [1:0] SelR = 2'd0;
  localparam logic [1:0] SelG = 2'd1;
  localparam logic [1:0] SelB = 2'd2;

endpackage

FILE: sv/pba_chan.sv
`timescale 1ns / 1ps

module pba_chan (
  input  logic [pba_pkg::ChanW-1:0]        a_i,
  input  logic [pba_pkg::ChanW-1:0]        b_i,
  input  pba_pkg::chmode_e                 mode_i,
  input  logic signed [pba_pkg::AmtW-1:0]  amount_i,
  output logic [pba_pkg::ChanW-1:0]        res_o
);
  import pba_pkg::*;

  logic        inv;
  logic [7:0]  ma;
  logic [7:0]  mb;
  logic [15:0] prod;
  logic [15:0] num;
  logic [16:0] qsum;
  logic [7:0]  quot;
  logic [7:0]  blend;
  logic [7:0]  diff;
  logic signed [10:0] sum;
  logic signed [18:0] scaled;
  logic [7:0]  add_sat;
  logic [7:0]  scale_sat;

  // Screen and the upper half of overlay work on complemented operands
  // (255 - x is the bitwise inverse), so one multiplier serves all blends.
  assign inv = (mode_i == CH_SCREEN) || ((mode_i == CH_OVERLAY) && b_i[7]);
  assign ma  = inv ? ~a_i : a_i;
  assign mb  = inv ? ~b_i : b_i;
  assign prod = ma * mb;
  assign num = ((mode_i == CH_OVERLAY) ? {prod[14:0], 1'b0} : prod) + 16'd127;

  // Exact floor(num / 255) for every num the blends can produce (at most 65152).
  assign qsum  = {1'b0, num} + 17'd1 + {9'd0, num[15:8]};
  assign quot  = qsum[15:8];
  assign blend = inv ? ~quot : quot;

  assign diff = (a_i > b_i) ? (a_i - b_i) : 8'd0;

  assign sum = $signed({3'b000, a_i}) + $signed({amount_i[AmtW-1], amount_i});
  always_comb begin
    if (sum < 0) begin
      add_sat = 8'd0;
    end else if (sum > 11'sd255) begin
      add_sat = 8'd255;
    end else begin
      add_sat = sum[7:0];
    end
  end

  assign scaled = $signed({1'b0, a_i}) * amount_i;
  always_comb begin
    if (scaled < 0) begin
      scale_sat = 8'd0;
    end else if (scaled > 19'sd255) begin
      scale_sat = 8'd255;
    end else begin
      scale_sat = scaled[7:0];
    end
  end

  always_comb begin
    case (mode_i)
      CH_PASS:    res_o = a_i;
      CH_LAYER:   res_o = b_i;
      CH_MUL:     res_o = blend;
      CH_SUB:     res_o = diff;
      CH_OVERLAY: res_o = blend;
      CH_SCREEN:  res_o = blend;
      CH_ADD:     res_o = add_sat;
      CH_SCALE:   res_o = scale_sat;
      default:    res_o = a_i;
    endcase
  end

endmodule

FILE: sv/pba_decode.sv
`timescale 1ns / 1ps

module pba_decode (
  input  logic [pba_pkg::OpW-1:0] op_i,
  output pba_pkg::ctrl_t          ctrl_o
);
  import pba_pkg::*;

  always_comb begin
    ctrl_o = '{mode_r: CH_PASS, mode_g: CH_PASS, mode_b: CH_PASS,
               src_sel: SelR, src_one: 1'b0, blue_sec: 1'b0};
    unique case (op_e'(op_i))
      OP_MUL: begin
        ctrl_o.mode_r = CH_MUL;
        ctrl_o.mode_g = CH_MUL;
        ctrl_o.mode_b = CH_MUL;
      end
      OP_SUB: begin
        ctrl_o.mode_r = CH_SUB;
        ctrl_o.mode_g = CH_SUB;
        ctrl_o.mode_b = CH_SUB;
      end
      OP_OVERLAY: begin
        ctrl_o.mode_r = CH_OVERLAY;
        ctrl_o.mode_g = CH_OVERLAY;
        ctrl_o.mode_b = CH_OVERLAY;
      end
      OP_SCREEN: begin
        ctrl_o.mode_r = CH_SCREEN;
        ctrl_o.mode_g = CH_SCREEN;
        ctrl_o.mode_b = CH_SCREEN;
      end
      OP_COMBINE: begin
        ctrl_o.mode_g   = CH_LAYER;
        ctrl_o.mode_b   = CH_LAYER;
        ctrl_o.blue_sec = 1'b1;
      end
      OP_ONLY_R: begin
        ctrl_o.src_one = 1'b1;
        ctrl_o.src_sel = SelR;
      end
      OP_ONLY_G: begin
        ctrl_o.src_one = 1'b1;
        ctrl_o.src_sel = SelG;
      end
      OP_ONLY_B: begin
        ctrl_o.src_one = 1'b1;
        ctrl_o.src_sel = SelB;
      end
      OP_ADD_R:   ctrl_o.mode_r = CH_ADD;
      OP_ADD_G:   ctrl_o.mode_g = CH_ADD;
      OP_ADD_B:   ctrl_o.mode_b = CH_ADD;
      OP_SCALE_R: ctrl_o.mode_r = CH_SCALE;
      OP_SCALE_G: ctrl_o.mode_g = CH_SCALE;
      OP_SCALE_B: ctrl_o.mode_b = CH_SCALE;
      default: begin
        // Unused codes leave the base pixel untouched.
        ctrl_o.src_one = 1'b0;
      end
    endcase
  end

endmodule

FILE: sv/pixel_blend_and_adjust.sv
`timescale 1ns / 1ps

// Per-pixel RGB blend and adjust engine. One pixel is taken per clock while
// the input is not stalled. Each pixel is held in the input register, passes
// once through the channel arithmetic (a single 8x8 multiply with a
// divide-by-255 correction, or an add or 8x10 multiply with saturation) and
// is loaded into the output register when that register is free or being
// emptied. Throughput is one pixel per clock while the output is not
// stalled; the input register keeps accepting as long as it is empty or the
// output register is free or being emptied in the same cycle.
// The operation and amount registers are written through the cfg port and
// should only change while no pixel is in flight.
module pixel_blend_and_adjust (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [pba_pkg::AmtW-1:0]          cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [pba_pkg::ChanW-1:0]         base_red_i,
  input  logic [pba_pkg::ChanW-1:0]         base_green_i,
  input  logic [pba_pkg::ChanW-1:0]         base_blue_i,
  input  logic [pba_pkg::ChanW-1:0]         layer_red_i,
  input  logic [pba_pkg::ChanW-1:0]         layer_green_i,
  input  logic [pba_pkg::ChanW-1:0]         layer_blue_i,
  input  logic [pba_pkg::ChanW-1:0]         second_layer_blue_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pba_pkg::ChanW-1:0]         out_red_o,
  output logic [pba_pkg::ChanW-1:0]         out_green_o,
  output logic [pba_pkg::ChanW-1:0]         out_blue_o
);
  import pba_pkg::*;

  logic [OpW-1:0]         op_q;
  logic signed [AmtW-1:0] amount_q;

  logic             s1_valid_q;
  logic [ChanW-1:0] ar_q, ag_q, ab_q, br_q, bg_q, bb_q, sb_q;
  logic             out_valid_q;
  logic [ChanW-1:0] res_r_q, res_g_q, res_b_q;

  logic             in_xfer;
  logic             advance;
  ctrl_t            ctrl;
  logic [ChanW-1:0] src;
  logic [ChanW-1:0] a_r, a_g, a_b, b_b;
  logic [ChanW-1:0] res_r_d, res_g_d, res_b_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q     <= '0;
      amount_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgIdxOperation) begin
        op_q <= cfg_wdata_i[OpW-1:0];
      end else if (cfg_idx_i == CfgIdxAmount) begin
        amount_q <= $signed(cfg_wdata_i);
      end
    end
  end

  // The input stage moves on whenever the output register is empty or its
  // pixel is being transferred out in this cycle.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ar_q <= base_red_i;
      ag_q <= base_green_i;
      ab_q <= base_blue_i;
      br_q <= layer_red_i;
      bg_q <= layer_green_i;
      bb_q <= layer_blue_i;
      sb_q <= second_layer_blue_i;
    end
  end

  pba_decode u_decode (
    .op_i   (op_q),
    .ctrl_o (ctrl)
  );

  always_comb begin
    case (ctrl.src_sel)
      SelR:    src = ar_q;
      SelG:    src = ag_q;
      SelB:    src = ab_q;
      default: src = ar_q;
    endcase
  end

  assign a_r = ctrl.src_one ? src : ar_q;
  assign a_g = ctrl.src_one ? src : ag_q;
  assign a_b = ctrl.src_one ? src : ab_q;
  assign b_b = ctrl.blue_sec ? sb_q : bb_q;

  pba_chan u_chan_r (
    .a_i      (a_r),
    .b_i      (br_q),
    .mode_i   (ctrl.mode_r),
    .amount_i (amount_q),
    .res_o    (res_r_d)
  );

  pba_chan u_chan_g (
    .a_i      (a_g),
    .b_i      (bg_q),
    .mode_i   (ctrl.mode_g),
    .amount_i (amount_q),
    .res_o    (res_g_d)
  );

  pba_chan u_chan_b (
    .a_i      (a_b),
    .b_i      (b_b),
    .mode_i   (ctrl.mode_b),
    .amount_i (amount_q),
    .res_o    (res_b_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      res_r_q <= res_r_d;
      res_g_q <= res_g_d;
      res_b_q <= res_b_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = res_r_q;
  assign out_green_o = res_g_q;
  assign out_blue_o  = res_b_q;

endmodule

FILE: sv/pba_checker.sv
`timescale 1ns / 1ps

module pba_props (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_i,
  input logic                      out_valid_i,
  input logic                      out_stall_i,
  input logic [pba_pkg::ChanW-1:0] out_red_i,
  input logic [pba_pkg::ChanW-1:0] out_green_i,
  input logic [pba_pkg::ChanW-1:0] out_blue_i
);
  import pba_pkg::*;

  // A result held by the sink keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_red_i) &&
      $stable(out_green_i) && $stable(out_blue_i))
    else $error("stalled result changed or vanished");

  // The input side only backs up when the output is full and blocked.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_i |-> out_valid_i && out_stall_i)
    else $error("input stalled while output could drain");

  // A result only leaves through a completed transfer.
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_i) |-> $past(!out_stall_i))
    else $error("result dropped without a transfer");

  // An accepted pixel reaches the output if the output is not stalled while it waits in the input register.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_i) ##1 !out_stall_i |=> out_valid_i)
    else $error("accepted pixel did not reach the output");

endmodule

bind pixel_blend_and_adjust pba_props u_pba_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_red_i   (out_red_o),
  .out_green_i (out_green_o),
  .out_blue_i  (out_blue_o)
);

FILE: sim/pba_checker.sv
`timescale 1ns / 1ps

module pba_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [pba_pkg::AmtW-1:0]  cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [pba_pkg::ChanW-1:0] base_red_i,
  input  logic [pba_pkg::ChanW-1:0] base_green_i,
  input  logic [pba_pkg::ChanW-1:0] base_blue_i,
  input  logic [pba_pkg::ChanW-1:0] layer_red_i,
  input  logic [pba_pkg::ChanW-1:0] layer_green_i,
  input  logic [pba_pkg::ChanW-1:0] layer_blue_i,
  input  logic [pba_pkg::ChanW-1:0] second_layer_blue_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [pba_pkg::ChanW-1:0] out_red_i,
  input  logic [pba_pkg::ChanW-1:0] out_green_i,
  input  logic [pba_pkg::ChanW-1:0] out_blue_i,
  output int                        fail_cnt_o,
  output int                        pend_cnt_o,
  output int                        seen_cnt_o
);

  import pba_pkg::*;

  typedef logic [ChanW-1:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  logic [OpW-1:0]         op_q  = '0;
  logic signed [AmtW-1:0] amt_q = '0;
  rgb_t                   pixels_due_q[$];
  int                     mism_cnt = 0;
  int                     seen_cnt = 0;

  function automatic chan_t clamp_u8(input int v);
    if (v < 0) return '0;
    if (v > 255) return '1;
    return chan_t'(v);
  endfunction

  // Two-layer blend of one channel; the divide by 255 is rounded half up.
  function automatic chan_t blend_channel(input logic [OpW-1:0] op, input chan_t a,
                                          input chan_t b);
    int unsigned ua;
    int unsigned ub;
    int unsigned r;
    ua = a;
    ub = b;
    r  = ua;
    case (op)
      OP_MUL:    r = (ua * ub + 127) / 255;
      OP_SUB:    r = (ua > ub) ? ua - ub : 0;
      OP_SCREEN: r = 255 - ((255 - ua) * (255 - ub) + 127) / 255;
      OP_OVERLAY: begin
        if (ub <= 127) begin
          r = (2 * ua * ub + 127) / 255;
          if (r > 255) r = 255;
        end else begin
          r = 255 - (2 * (255 - ua) * (255 - ub) + 127) / 255;
        end
      end
      default: ;
    endcase
    return chan_t'(r);
  endfunction

  function automatic rgb_t predict_pixel(input rgb_t base, input rgb_t layer,
                                         input chan_t sec_blue);
    chan_t ba[3];
    chan_t la[3];
    chan_t ra[3];
    rgb_t  res;
    int    k;
    ba = '{base.red, base.green, base.blue};
    la = '{layer.red, layer.green, layer.blue};
    ra = ba;
    case (op_q) inside
      OP_MUL, OP_SUB, OP_OVERLAY, OP_SCREEN: begin
        for (k = 0; k < 3; k++) ra[k] = blend_channel(op_q, ba[k], la[k]);
      end
      OP_COMBINE: begin
        ra[1] = la[1];
        ra[2] = sec_blue;
      end
      OP_ONLY_R, OP_ONLY_G, OP_ONLY_B: begin
        k = int'(op_q) - int'(OP_ONLY_R);
        ra = '{ba[k], ba[k], ba[k]};
      end
      OP_ADD_R, OP_ADD_G, OP_ADD_B: begin
        k = int'(op_q) - int'(OP_ADD_R);
        ra[k] = clamp_u8(int'(ba[k]) + int'(amt_q));
      end
      OP_SCALE_R, OP_SCALE_G, OP_SCALE_B: begin
        k = int'(op_q) - int'(OP_SCALE_R);
        ra[k] = clamp_u8(int'(ba[k]) * int'(amt_q));
      end
      default: ;  // spare codes pass the base pixel through
    endcase
    res.red   = ra[0];
    res.green = ra[1];
    res.blue  = ra[2];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    rgb_t got;
    rgb_t want;
    rgb_t due;
    if (!rst_ni) begin
      op_q  = '0;
      amt_q = '0;
      pixels_due_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{out_red_i, out_green_i, out_blue_i};
        seen_cnt++;
        if (pixels_due_q.size() == 0) begin
          mism_cnt++;
          if (mism_cnt <= 10)
            $display("[%0t] unexpected result r=%0d g=%0d b=%0d", $time,
                     got.red, got.green, got.blue);
        end else begin
          want = pixels_due_q.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue) begin
            mism_cnt++;
            if (mism_cnt <= 10)
              $display({"[%0t] result %0d op %0d amt %0d: ",
                        "expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d"},
                       $time, seen_cnt, op_q, amt_q, want.red, want.green,
                       want.blue, got.red, got.green, got.blue);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        due = predict_pixel('{base_red_i, base_green_i, base_blue_i},
                            '{layer_red_i, layer_green_i, layer_blue_i},
                            second_layer_blue_i);
        pixels_due_q = {pixels_due_q, due};
      end
      // Register writes are to happen only while no pixel is in flight; this model does not enforce it.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgIdxOperation: op_q  = cfg_wdata_i[OpW-1:0];
          CfgIdxAmount:    amt_q = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    fail_cnt_o <= mism_cnt;
    pend_cnt_o <= pixels_due_q.size();
    seen_cnt_o <= seen_cnt;
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import pba_pkg::*;

  localparam int ItemTarget = 700;
  localparam int HoldCycles = 64;
  localparam int TailCycles = 10;
  localparam int LimitNs    = 4_000_000;

  // Operation codes that the block leaves unused.
  localparam logic [OpW-1:0] OpSpareLo = 4'd14;
  localparam logic [OpW-1:0] OpSpareHi = 4'd15;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic             cfg_idx   = 1'b0;
  logic [AmtW-1:0]  cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic [ChanW-1:0] base_r    = '0;
  logic [ChanW-1:0] base_g    = '0;
  logic [ChanW-1:0] base_b    = '0;
  logic [ChanW-1:0] layer_r   = '0;
  logic [ChanW-1:0] layer_g   = '0;
  logic [ChanW-1:0] layer_b   = '0;
  logic [ChanW-1:0] sec_b     = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ChanW-1:0] out_r;
  logic [ChanW-1:0] out_g;
  logic [ChanW-1:0] out_b;

  bit hold_req = 1'b0;
  bit rx_quiet = 1'b0;
  bit tx_quiet = 1'b0;
  int sent_cnt = 0;
  int phase_cnt = 0;
  int fail_cnt;
  int pend_cnt;
  int seen_cnt;

  pixel_blend_and_adjust u_top (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_idx_i           (cfg_idx),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .base_red_i          (base_r),
    .base_green_i        (base_g),
    .base_blue_i         (base_b),
    .layer_red_i         (layer_r),
    .layer_green_i       (layer_g),
    .layer_blue_i        (layer_b),
    .second_layer_blue_i (sec_b),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .out_red_o           (out_r),
    .out_green_o         (out_g),
    .out_blue_o          (out_b)
  );

  pba_checker u_chk (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_idx_i           (cfg_idx),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .base_red_i          (base_r),
    .base_green_i        (base_g),
    .base_blue_i         (base_b),
    .layer_red_i         (layer_r),
    .layer_green_i       (layer_g),
    .layer_blue_i        (layer_b),
    .second_layer_blue_i (sec_b),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .out_red_i           (out_r),
    .out_green_i         (out_g),
    .out_blue_i          (out_b),
    .fail_cnt_o          (fail_cnt),
    .pend_cnt_o          (pend_cnt),
    .seen_cnt_o          (seen_cnt)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(LimitNs);
    $display("Timed out with %0d results still due.", pend_cnt);
    $display("simulation failed");
    $finish;
  end

  // Output side: random stalls, some long ones, quiet stretches, and a long
  // hold on request so that the pipeline fills and backs up into the input.
  initial begin : rx_side
    int roll;
    int len;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (rx_quiet) begin
        out_stall <= 1'b0;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          out_stall <= 1'b1;
          len = $urandom_range(10, 40);
          repeat (len) @(posedge clk);
          out_stall <= 1'b0;
        end else begin
          out_stall <= (roll < 25);
        end
      end
    end
  end

  task automatic tx_gap();
    int roll;
    int len;
    if (tx_quiet) return;
    roll = $urandom_range(0, 99);
    if (roll < 70) len = 0;
    else if (roll < 96) len = $urandom_range(1, 3);
    else len = $urandom_range(8, 40);
    if (len > 0) begin
      in_valid <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  task automatic send_pixel(input logic [ChanW-1:0] br, bg, bb, lr, lg, lb, sb);
    tx_gap();
    in_valid <= 1'b1;
    base_r   <= br;
    base_g   <= bg;
    base_b   <= bb;
    layer_r  <= lr;
    layer_g  <= lg;
    layer_b  <= lb;
    sec_b    <= sb;
    do @(posedge clk); while (in_stall);
    sent_cnt++;
  endtask

  // Stop offering pixels and wait until every result has come out.
  task automatic drain_pixels();
    in_valid <= 1'b0;
    do @(posedge clk); while (pend_cnt != 0);
    repeat (4) @(posedge clk);
  endtask

  // Writes both registers back to back; the upper bits of the operation
  // word are random since only the low bits are kept.
  task automatic configure(input logic [OpW-1:0] op, input int amt);
    logic [AmtW-1:0] word;
    drain_pixels();
    word = AmtW'($urandom);
    word[OpW-1:0] = op;
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgIdxOperation;
    cfg_wdata <= word;
    @(posedge clk);
    word = AmtW'(amt);
    cfg_idx   <= CfgIdxAmount;
    cfg_wdata <= word;
    @(posedge clk);
    cfg_we <= 1'b0;
    phase_cnt++;
  endtask

  function automatic logic [ChanW-1:0] rand_chan();
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0:       return '0;
      1:       return '1;
      2:       return ChanW'($urandom_range(127, 128));
      default: return ChanW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int rand_amount(input logic [OpW-1:0] op);
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return -512;
    if (roll == 1) return 511;
    if (op >= OP_SCALE_R && op <= OP_SCALE_B) begin
      // Small factors keep most products inside the channel range.
      if (roll < 5) return $urandom_range(0, 3);
      if (roll < 7) return -int'($urandom_range(1, 3));
      return int'($urandom_range(0, 1023)) - 512;
    end
    if (op >= OP_ADD_R && op <= OP_ADD_B)
      return int'($urandom_range(0, 600)) - 300;
    return int'($urandom_range(0, 1023)) - 512;
  endfunction

  task automatic send_rand_pixel();
    send_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan(), rand_chan(),
               rand_chan(), rand_chan());
  endtask

  initial begin : stimulus
    logic [OpW-1:0] op;
    int             rnd_phase;
    int             n_items;
    int             k;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: channel extremes and the overlay switch point.
    configure(OP_MUL, 0);
    send_pixel(0, 255, 255, 255, 0, 255, 0);
    send_pixel(128, 127, 200, 127, 128, 100, 255);
    configure(OP_SUB, 0);
    send_pixel(0, 255, 255, 255, 0, 255, 0);
    send_pixel(128, 127, 200, 127, 128, 100, 255);
    configure(OP_OVERLAY, 0);
    send_pixel(0, 255, 255, 255, 0, 255, 0);
    send_pixel(128, 127, 200, 127, 128, 100, 255);
    configure(OP_SCREEN, 0);
    send_pixel(0, 255, 255, 255, 0, 255, 0);
    send_pixel(128, 127, 200, 127, 128, 100, 255);
    configure(OP_COMBINE, 0);
    send_pixel(0, 255, 1, 255, 0, 254, 255);
    configure(OP_ONLY_R, 0);
    send_pixel(10, 200, 77, 1, 2, 3, 4);
    configure(OP_ONLY_G, 0);
    send_pixel(10, 200, 77, 1, 2, 3, 4);
    configure(OP_ONLY_B, 0);
    send_pixel(10, 200, 77, 1, 2, 3, 4);
    configure(OP_ADD_R, 511);
    send_pixel(255, 0, 128, 9, 9, 9, 9);
    configure(OP_ADD_G, -512);
    send_pixel(255, 200, 9, 0, 0, 0, 0);
    configure(OP_ADD_B, 1);
    send_pixel(0, 0, 255, 255, 255, 255, 255);
    configure(OP_SCALE_R, 511);
    send_pixel(1, 50, 60, 0, 0, 0, 0);
    // A negative factor gives a negative product, which clips to zero.
    configure(OP_SCALE_G, -1);
    send_pixel(3, 255, 60, 0, 0, 0, 0);
    configure(OP_SCALE_B, 0);
    send_pixel(3, 4, 255, 0, 0, 0, 0);
    configure(OpSpareLo, -512);
    send_pixel(11, 22, 33, 44, 55, 66, 77);
    configure(OpSpareHi, 511);
    send_pixel(255, 0, 128, 0, 255, 127, 1);

    // Random part: one operation setting per phase.
    rnd_phase = 0;
    while (sent_cnt < ItemTarget) begin
      op = OpW'($urandom_range(0, 15));
      configure(op, rand_amount(op));
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      if (rnd_phase == 2) begin
        tx_quiet = 1'b1;
        rx_quiet = 1'b0;
      end
      n_items = $urandom_range(15, 50);
      for (k = 0; k < n_items; k++) begin
        if (rnd_phase == 2 && k == 2) hold_req = 1'b1;
        if (k == n_items / 2 && (rnd_phase == 4 || $urandom_range(0, 5) == 0))
          drain_pixels();
        send_rand_pixel();
      end
      rnd_phase++;
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pend_cnt != 0);
    repeat (TailCycles) @(posedge clk);
    $display("Sent %0d pixels under %0d register settings, %0d results checked.",
             sent_cnt, phase_cnt, seen_cnt);
    $display("Covered every operation and spare code, saturating amounts, "
             , "output holds and input drains.");
    if (fail_cnt == 0 && pend_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results missing.", fail_cnt, pend_cnt);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
